// ----- rtl/core/csem_pkg.sv -----
package csem_pkg;

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_LOCK   = 2'd1;
  localparam logic [1:0] FUNC_UNLOCK = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_SUSPENDED = 2'd1;
  localparam logic [1:0] ST_WOKEN     = 2'd2;
  localparam logic [1:0] ST_ERROR     = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] sem_id;
    logic [4:0] caller_pid;
    logic [7:0] initial_count;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] new_sem_id;
    logic [4:0] woken_pid;
  } rsp_t;

endpackage

// ----- rtl/core/csem_ram.sv -----
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/counting_semaphore_wait_queue.sv -----
// Counting semaphore bank with a FIFO wait queue per semaphore. Create hands out
// ids 0, 1, 2, ... (never reused) and reports error once min(SEM_COUNT, 32) ids
// are gone; lock decrements a positive count or queues the caller (status
// suspended, error when min(PROC_COUNT, 32) callers already wait); unlock wakes
// the oldest waiter or increments the count, saturating at 255. Lock or unlock
// of an id not yet created, and the unused function code, give status error.
// One request is in flight at a time: a request reads the descriptor memory,
// then updates and writes it back, and an unlock that wakes a waiter also
// reads the wait-slot memory at the head found in the descriptor. The next
// request is accepted while a result waits in the output register; a request
// stalls only in its final state if that register is still full. No clearing
// pass is needed after reset.
module counting_semaphore_wait_queue #(
  parameter int SEM_COUNT  = 32,
  parameter int PROC_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  csem_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output csem_pkg::rsp_t    rsp
);

  localparam int ID_LIMIT = (SEM_COUNT < 32) ? SEM_COUNT : 32;
  localparam int QCAP     = (PROC_COUNT < 32) ? PROC_COUNT : 32;
  localparam int IDW      = $clog2(ID_LIMIT);
  localparam int QW       = $clog2(QCAP);
  localparam int LW       = $clog2(QCAP + 1);
  localparam int NW       = $clog2(ID_LIMIT + 1);
  localparam int SLOT_DEPTH = ID_LIMIT << QW;

  typedef struct packed {
    logic [7:0]    count;
    logic [4:0]    creator;
    logic [QW-1:0] head;
    logic [QW-1:0] tail;
    logic [LW-1:0] len;
  } desc_t;

  localparam int DW = $bits(desc_t);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    EXEC = 3'b010,
    WAKE = 3'b100
  } state_t;

  state_t          state, state_next;
  csem_pkg::req_t  req_q;
  logic [NW-1:0]   next_free_id, next_free_id_next;
  csem_pkg::rsp_t  rsp_next;
  logic            rsp_load;

  logic            desc_re, desc_we;
  logic [IDW-1:0]  desc_waddr;
  desc_t           desc_rd, desc_wdata;
  logic [DW-1:0]   desc_rd_raw;

  logic                slot_re, slot_we;
  logic [IDW+QW-1:0]   slot_raddr, slot_waddr;
  logic [4:0]          slot_rd;

  logic            out_free, sid_ok, create_ok;
  logic [QW-1:0]   tail_inc, head_inc;

  assign req_ready = (state == IDLE);
  assign desc_re   = req_valid && req_ready;
  assign desc_rd   = desc_t'(desc_rd_raw);
  assign out_free  = !rsp_valid || rsp_ready;
  assign sid_ok    = {1'b0, req_q.sem_id} < 6'(next_free_id);
  assign create_ok = next_free_id < NW'(ID_LIMIT);
  assign tail_inc  = (desc_rd.tail == QW'(QCAP - 1)) ? '0 : desc_rd.tail + 1'b1;
  assign head_inc  = (desc_rd.head == QW'(QCAP - 1)) ? '0 : desc_rd.head + 1'b1;
  assign slot_raddr = {req_q.sem_id[IDW-1:0], desc_rd.head};
  assign slot_waddr = {req_q.sem_id[IDW-1:0], desc_rd.tail};

  csem_ram #(.WIDTH(DW), .DEPTH(ID_LIMIT)) u_desc_ram (
    .clk     (clk),
    .wr_en   (desc_we),
    .wr_addr (desc_waddr),
    .wr_data (desc_wdata),
    .rd_en   (desc_re),
    .rd_addr (req.sem_id[IDW-1:0]),
    .rd_data (desc_rd_raw)
  );

  csem_ram #(.WIDTH(5), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (req_q.caller_pid),
    .rd_en   (slot_re),
    .rd_addr (slot_raddr),
    .rd_data (slot_rd)
  );

  always_comb begin
    state_next        = state;
    next_free_id_next = next_free_id;
    desc_we           = 1'b0;
    desc_waddr        = req_q.sem_id[IDW-1:0];
    desc_wdata        = desc_rd;
    slot_we           = 1'b0;
    slot_re           = 1'b0;
    rsp_load          = 1'b0;
    rsp_next          = '{status: csem_pkg::ST_ERROR, new_sem_id: 5'd0, woken_pid: 5'd0};
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        if (req_q.func == csem_pkg::FUNC_UNLOCK && sid_ok && desc_rd.len != '0) begin
          // pop: advance head now, waiter pid arrives next cycle
          desc_we         = 1'b1;
          desc_wdata.head = head_inc;
          desc_wdata.len  = desc_rd.len - 1'b1;
          slot_re         = 1'b1;
          state_next      = WAKE;
        end else if (out_free) begin
          rsp_load   = 1'b1;
          state_next = IDLE;
          priority if (req_q.func == csem_pkg::FUNC_CREATE) begin
            if (create_ok) begin
              desc_we           = 1'b1;
              desc_waddr        = next_free_id[IDW-1:0];
              desc_wdata        = '{count: req_q.initial_count, creator: req_q.caller_pid,
                                    head: '0, tail: '0, len: '0};
              next_free_id_next = next_free_id + 1'b1;
              rsp_next.status   = csem_pkg::ST_DONE;
              rsp_next.new_sem_id = 5'(next_free_id);
            end
          end else if (req_q.func == csem_pkg::FUNC_LOCK && sid_ok) begin
            if (desc_rd.count != 8'd0) begin
              desc_we          = 1'b1;
              desc_wdata.count = desc_rd.count - 1'b1;
              rsp_next.status  = csem_pkg::ST_DONE;
            end else if (desc_rd.len != LW'(QCAP)) begin
              desc_we         = 1'b1;
              slot_we         = 1'b1;
              desc_wdata.tail = tail_inc;
              desc_wdata.len  = desc_rd.len + 1'b1;
              rsp_next.status = csem_pkg::ST_SUSPENDED;
            end
          end else if (req_q.func == csem_pkg::FUNC_UNLOCK && sid_ok) begin
            desc_we = 1'b1;
            if (desc_rd.count != csem_pkg::COUNT_MAX) begin
              desc_wdata.count = desc_rd.count + 1'b1;
            end
            rsp_next.status = csem_pkg::ST_DONE;
          end else begin
            rsp_next.status = csem_pkg::ST_ERROR;
          end
        end
      end
      WAKE: begin
        if (out_free) begin
          rsp_load           = 1'b1;
          rsp_next.status    = csem_pkg::ST_WOKEN;
          rsp_next.woken_pid = slot_rd;
          state_next         = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      next_free_id <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      next_free_id <= next_free_id_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_re) begin
      req_q <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
